@@ rtl/lut3d_pkg.sv @@
// Shared constants for the trilinear 3D color lookup table.
// No dependencies; imported by lut3d_trilinear_color.
package lut3d_pkg;

    localparam int DIV_W      = 5;        // grid_division register width
    localparam int NODE_W     = 5;        // lattice coordinate field width
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [DIV_W-1:0]      DIV_RESET = 5'd2;
    localparam logic [APB_ADDR_W-1:0] ADDR_DIV  = 3'd0;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam int NUM_BANKS = 8;         // one bank per (r,g,b) parity

    typedef logic [2:0] bank_sel_t;

endpackage

@@ rtl/lut3d_trilinear_color.sv @@
// Trilinear 3D color lookup table: banked lattice memory and blend pipeline.
// Depends on lut3d_pkg.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  input   | s_valid / s_ready      | s_cmd, s_node_*, s_entry_*, s_coord_*
//  result  | m_valid / m_ready      | m_mixed_*, m_byte_*
//  config  | psel/penable/pwrite    | paddr, pwdata, prdata, pready (always 1)
//
// One item per clock while m_ready does not hold the pipeline. A lookup's result passes
// through bank read, red blend, green blend, blue blend and byte conversion stages.
// Node writes produce no result.
// The lattice sits in eight banks picked by the parity of (r,g,b), so the
// eight corners of a cell always land in eight different banks: one read
// port per bank is enough for a lookup every cycle. A clamped axis reads its
// base node for both corners.
// Reset (aresetn, synchronous) clears the pipeline valids and sets
// grid_division to 2; lattice contents are undefined until written.
// Each stage holds while the one after it is full and stalled, so bubbles
// close up and a new item is taken while a finished result waits.
module lut3d_trilinear_color
    import lut3d_pkg::*;
#(
    parameter int MAX_DIVISION = 17,
    parameter int VALUE_BITS   = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cmd,
    input  logic [NODE_W-1:0]     s_node_red,
    input  logic [NODE_W-1:0]     s_node_green,
    input  logic [NODE_W-1:0]     s_node_blue,
    input  logic [VALUE_BITS-1:0] s_entry_red,
    input  logic [VALUE_BITS-1:0] s_entry_green,
    input  logic [VALUE_BITS-1:0] s_entry_blue,
    input  logic [VALUE_BITS:0]   s_coord_red,
    input  logic [VALUE_BITS:0]   s_coord_green,
    input  logic [VALUE_BITS:0]   s_coord_blue,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_BITS-1:0] m_mixed_red,
    output logic [VALUE_BITS-1:0] m_mixed_green,
    output logic [VALUE_BITS-1:0] m_mixed_blue,
    output logic [7:0]            m_byte_red,
    output logic [7:0]            m_byte_green,
    output logic [7:0]            m_byte_blue
);

    localparam int VB         = VALUE_BITS;
    localparam int CW         = VB + 1;                       // coordinate width
    localparam int DW         = $clog2(MAX_DIVISION + 1);     // division width
    localparam int LW         = $clog2(MAX_DIVISION);         // lattice coord width
    localparam int HALF_N     = (MAX_DIVISION + 1) / 2;       // nodes per axis per bank
    localparam int BANK_DEPTH = HALF_N * HALF_N * HALF_N;
    localparam int AW         = $clog2(BANK_DEPTH);
    localparam int EW         = 3 * VB;                       // packed {b,g,r} entry
    localparam int PW         = CW + LW;                      // scaled coordinate width

    typedef struct packed {
        logic [LW-1:0] lo;
        logic [LW-1:0] hi;
        logic [VB-1:0] frac;
    } axis_t;

    // ---------------- configuration ----------------
    logic [DIV_W-1:0] div_reg;
    logic [DW-1:0]    div_eff;
    logic [LW-1:0]    div_m1;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == ADDR_DIV[APB_ADDR_W-1:2]);
    assign prdata = (paddr[APB_ADDR_W-1:2] == ADDR_DIV[APB_ADDR_W-1:2])
                    ? APB_DATA_W'(div_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_reg <= DIV_RESET;
        end else if (cfg_wr) begin
            div_reg <= pwdata[DIV_W-1:0];
        end
    end

    // out-of-range division values act as the nearest legal one
    always_comb begin
        if (int'(div_reg) < 2) begin
            div_eff = DW'(2);
        end else if (int'(div_reg) > MAX_DIVISION) begin
            div_eff = DW'(MAX_DIVISION);
        end else begin
            div_eff = DW'(div_reg);
        end
        div_m1 = LW'(div_eff - DW'(1));
    end

    // ---------------- helpers ----------------
    function automatic axis_t split_axis(input logic [CW-1:0] coord, input logic [LW-1:0] dm1);
        logic [CW-1:0] cc;
        logic [PW-1:0] p;
        logic [LW:0]   base;
        axis_t         a;
        cc   = (coord > CW'(1) << VB) ? (CW'(1) << VB) : coord;
        p    = PW'(cc) * PW'(dm1);
        base = p[PW-1:VB];
        if (base >= (LW+1)'(dm1)) begin
            a.lo   = dm1;
            a.hi   = dm1;
            a.frac = '0;
        end else begin
            a.lo   = base[LW-1:0];
            a.hi   = base[LW-1:0] + LW'(1);
            a.frac = p[VB-1:0];
        end
        return a;
    endfunction

    function automatic logic [AW-1:0] bank_addr(input int rh, input int gh, input int bh);
        return AW'(rh + gh * HALF_N + bh * HALF_N * HALF_N);
    endfunction

    // (a*(1-f) + b*f + 1/2) >> VB, written as a + (b-a)*f
    function automatic logic [VB-1:0] blend(input logic [VB-1:0] a, input logic [VB-1:0] b,
                                            input logic [VB-1:0] f);
        logic signed [VB:0]     diff;
        logic signed [2*VB+1:0] prod;
        logic signed [2*VB+2:0] acc;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        prod = diff * $signed({1'b0, f});
        acc  = $signed({3'b000, a, {VB{1'b0}}}) + (2*VB+3)'(prod)
             + $signed({{(VB+3){1'b0}}, 1'b1, {(VB-1){1'b0}}});
        return acc[2*VB-1:VB];
    endfunction

    // ---------------- pipeline handshake ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic s_fire, rd_en, wr_en;

    assign rdy5    = !v5_reg || m_ready;
    assign rdy4    = !v4_reg || rdy5;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign m_valid = v5_reg;

    assign s_fire = s_valid && s_ready;
    assign rd_en  = s_fire && (s_cmd == CMD_LOOKUP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= rd_en;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
            if (rdy5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    // ---------------- stage 0: address generation ----------------
    axis_t           ax_r, ax_g, ax_b;
    logic [AW-1:0]   rd_addr [NUM_BANKS];
    bank_sel_t       wr_bank;
    logic [AW-1:0]   wr_addr;
    logic [EW-1:0]   wr_data;

    assign ax_r = split_axis(s_coord_red, div_m1);
    assign ax_g = split_axis(s_coord_green, div_m1);
    assign ax_b = split_axis(s_coord_blue, div_m1);

    // bank k takes the corner whose coordinate parities equal k's bits
    always_comb begin
        logic [LW-1:0] cr, cg, cb;
        for (int k = 0; k < NUM_BANKS; k++) begin
            cr = (ax_r.lo[0] == k[0]) ? ax_r.lo : ax_r.hi;
            cg = (ax_g.lo[0] == k[1]) ? ax_g.lo : ax_g.hi;
            cb = (ax_b.lo[0] == k[2]) ? ax_b.lo : ax_b.hi;
            rd_addr[k] = bank_addr(int'(cr >> 1), int'(cg >> 1), int'(cb >> 1));
        end
    end

    assign wr_en   = s_fire && (s_cmd == CMD_WRITE)
                     && (int'(s_node_red) < int'(div_eff))
                     && (int'(s_node_green) < int'(div_eff))
                     && (int'(s_node_blue) < int'(div_eff));
    assign wr_bank = {s_node_blue[0], s_node_green[0], s_node_red[0]};
    assign wr_addr = bank_addr(int'(s_node_red >> 1), int'(s_node_green >> 1),
                               int'(s_node_blue >> 1));
    assign wr_data = {s_entry_blue, s_entry_green, s_entry_red};

    // ---------------- lattice banks ----------------
    logic [EW-1:0] rd_data_reg [NUM_BANKS];

    for (genvar gb = 0; gb < NUM_BANKS; gb++) begin : g_bank
        logic [EW-1:0] mem [BANK_DEPTH];
        always_ff @(posedge aclk) begin
            if (wr_en && wr_bank == bank_sel_t'(gb)) begin
                mem[wr_addr] <= wr_data;
            end
            if (rd_en) begin
                rd_data_reg[gb] <= mem[rd_addr[gb]];
            end
        end
    end

    // ---------------- stage 1: read data + fractions ----------------
    logic          rpar1_reg, gpar1_reg, bpar1_reg;
    logic          rcl1_reg, gcl1_reg, bcl1_reg;      // axis clamped: lo == hi
    logic [VB-1:0] rf1_reg, gf1_reg, bf1_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rpar1_reg <= ax_r.lo[0];
            gpar1_reg <= ax_g.lo[0];
            bpar1_reg <= ax_b.lo[0];
            rcl1_reg  <= (ax_r.lo == ax_r.hi);
            gcl1_reg  <= (ax_g.lo == ax_g.hi);
            bcl1_reg  <= (ax_b.lo == ax_b.hi);
            rf1_reg   <= ax_r.frac;
            gf1_reg   <= ax_g.frac;
            bf1_reg   <= ax_b.frac;
        end
    end

    // ---------------- stage 2: blend along red ----------------
    // x2_reg[j][ch]: j[0] selects green lo/hi, j[1] blue lo/hi
    logic [VB-1:0] x2_reg [4][3];
    logic [VB-1:0] gf2_reg, bf2_reg;

    always_ff @(posedge aclk) begin
        bank_sel_t     klo, khi;
        logic [EW-1:0] elo, ehi;
        if (rdy2 && v1_reg) begin
            for (int j = 0; j < 4; j++) begin
                klo = {bpar1_reg ^ (j[1] & !bcl1_reg), gpar1_reg ^ (j[0] & !gcl1_reg),
                       rpar1_reg};
                khi = {bpar1_reg ^ (j[1] & !bcl1_reg), gpar1_reg ^ (j[0] & !gcl1_reg),
                       rpar1_reg ^ !rcl1_reg};
                elo = rd_data_reg[klo];
                ehi = rd_data_reg[khi];
                for (int ch = 0; ch < 3; ch++) begin
                    x2_reg[j][ch] <= blend(elo[ch*VB +: VB], ehi[ch*VB +: VB], rf1_reg);
                end
            end
            gf2_reg <= gf1_reg;
            bf2_reg <= bf1_reg;
        end
    end

    // ---------------- stage 3: blend along green ----------------
    logic [VB-1:0] y3_reg [2][3];
    logic [VB-1:0] bf3_reg;

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            for (int j = 0; j < 2; j++) begin
                for (int ch = 0; ch < 3; ch++) begin
                    y3_reg[j][ch] <= blend(x2_reg[2*j][ch], x2_reg[2*j+1][ch], gf2_reg);
                end
            end
            bf3_reg <= bf2_reg;
        end
    end

    // ---------------- stage 4: blend along blue ----------------
    logic [VB-1:0] v4val_reg [3];

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            for (int ch = 0; ch < 3; ch++) begin
                v4val_reg[ch] <= blend(y3_reg[0][ch], y3_reg[1][ch], bf3_reg);
            end
        end
    end

    // ---------------- stage 5: byte texels, output register ----------------
    logic [VB-1:0] mix5_reg  [3];
    logic [7:0]    byte5_reg [3];

    always_ff @(posedge aclk) begin
        logic [VB+9:0] t;
        if (rdy5 && v4_reg) begin
            for (int ch = 0; ch < 3; ch++) begin
                // floor(v*511/2^(VB+1) + 1/2), saturated
                t = (VB+10)'(v4val_reg[ch]) * (VB+10)'(511) + ((VB+10)'(1) << VB);
                byte5_reg[ch] <= t[VB+9] ? 8'hFF : t[VB+8:VB+1];
                mix5_reg[ch]  <= v4val_reg[ch];
            end
        end
    end

    assign m_mixed_red   = mix5_reg[0];
    assign m_mixed_green = mix5_reg[1];
    assign m_mixed_blue  = mix5_reg[2];
    assign m_byte_red    = byte5_reg[0];
    assign m_byte_green  = byte5_reg[1];
    assign m_byte_blue   = byte5_reg[2];

    // ---------------- assertions ----------------
    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !v5_reg |-> s_ready)
        else $error("input stalled with empty output stage");

    a_lookup_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |=> v1_reg)
        else $error("accepted lookup did not enter stage 1");

    a_div_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(div_eff) >= 2) && (int'(div_eff) <= MAX_DIVISION))
        else $error("effective division out of range");

    a_stage4_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg && !rdy4 |=> v4_reg && $stable(v4val_reg[0]))
        else $error("stalled blue stage lost its item");

endmodule
